>>> sv/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_UPDATE     = 3'd4,
    MODE_FIND_FIRST = 3'd5,
    MODE_FIND_LAST  = 3'd6,
    MODE_REPORT     = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

endpackage

>>> sv/deq_if.sv
`timescale 1ns / 1ps

interface deq_req_if #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic                         valid;
  logic                         ready;
  deq_pkg::mode_e               mode;
  logic signed [DATA_WIDTH-1:0] value;
  logic [IDX_W-1:0]             position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface deq_rsp_if #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
);
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TOTAL_W = DATA_WIDTH + IDX_W;

  logic                         valid;
  logic                         ready;
  deq_pkg::status_e             status;
  logic [IDX_W-1:0]             found_index;
  logic [CNT_W-1:0]             entry_count;
  logic signed [DATA_WIDTH-1:0] min_value;
  logic signed [DATA_WIDTH-1:0] max_value;
  logic signed [TOTAL_W-1:0]    total;

  modport source (output valid, output status, output found_index, output entry_count,
                  output min_value, output max_value, output total, input ready);
  modport sink   (input valid, input status, input found_index, input entry_count,
                  input min_value, input max_value, input total, output ready);
endinterface

>>> sv/double_ended_queue_with_search.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                              Accepted when
// req_i    in   mode, value, position                                valid && ready
// rsp_o    out  status, found_index, entry_count, min/max, total     valid && ready
//
// Push, pop and update: accept, then load the result register in S_EMIT once rsp_o is free.
// Find and report walk the entries in S_WALK: one ring-store read per cycle
// through the single registered read port, one compare/add step per entry.
// Reset clears pointers and count; the ring store itself is not cleared.
// A new request is taken while a finished result waits on a stalled rsp_o.

module double_ended_queue_with_search #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = IDX_W + 1;
  localparam int unsigned TOTAL_W = DATA_WIDTH + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  state_e state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_last_q, rd_last_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;

  mode_e                        mode_q, mode_d;
  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  logic [IDX_W-1:0]             rd_pos_q, rd_pos_d;
  logic [CNT_W-1:0]             walk_pos;

  status_e                      res_status_q, res_status_d;
  logic [IDX_W-1:0]             res_idx_q, res_idx_d;
  logic [CNT_W-1:0]             res_count_q, res_count_d;
  logic signed [DATA_WIDTH-1:0] res_min_q, res_min_d;
  logic signed [DATA_WIDTH-1:0] res_max_q, res_max_d;
  logic signed [TOTAL_W-1:0]    res_total_q, res_total_d;

  status_e                      out_status_q;
  logic [IDX_W-1:0]             out_idx_q;
  logic [CNT_W-1:0]             out_count_q;
  logic signed [DATA_WIDTH-1:0] out_min_q;
  logic signed [DATA_WIDTH-1:0] out_max_q;
  logic signed [TOTAL_W-1:0]    out_total_q;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [IDX_W-1:0]      rd_addr;
  logic signed [DATA_WIDTH-1:0] rd_val;
  logic                  match;

  assign req_i.ready = (state_q == S_IDLE);
  assign rd_val      = $signed(rd_data_q);
  assign match       = (rd_data_q == value_q);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    occ_d        = occ_q;
    iss_d        = iss_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = 1'b0;
    rd_pos_d     = rd_pos_q;
    hit_d        = hit_q;
    mode_d       = mode_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_count_d  = res_count_q;
    res_min_d    = res_min_q;
    res_max_d    = res_max_q;
    res_total_d  = res_total_q;
    mem_we       = 1'b0;
    mem_wa       = front_q;
    rd_addr      = front_q;
    walk_pos     = iss_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d       = req_i.mode;
          value_d      = req_i.value;
          res_status_d = ST_OK;
          res_idx_d    = '0;
          res_min_d    = '0;
          res_max_d    = '0;
          res_total_d  = '0;
          hit_d        = 1'b0;
          iss_d        = '0;
          state_d      = S_EMIT;
          case (req_i.mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (occ_q == CNT_W'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                occ_d  = occ_q + 1'b1;
                if (req_i.mode == MODE_PUSH_FRONT) begin
                  front_d = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
                  mem_wa  = front_d;
                end else begin
                  mem_wa = slot_of(front_q, occ_q);
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (occ_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                occ_d = occ_q - 1'b1;
                if (req_i.mode == MODE_POP_FRONT) begin
                  front_d = slot_of(front_q, CNT_W'(1));
                end
              end
            end
            MODE_UPDATE: begin
              if (CNT_W'(req_i.position) >= occ_q) begin
                res_status_d = ST_RANGE;
              end else begin
                mem_we = 1'b1;
                mem_wa = slot_of(front_q, CNT_W'(req_i.position));
              end
            end
            default: begin
              if (occ_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                state_d = S_WALK;
              end
            end
          endcase
          res_count_d = occ_d;
        end
      end
      S_WALK: begin
        if (iss_q != occ_q) begin
          walk_pos  = (mode_q == MODE_FIND_LAST) ? occ_q - 1'b1 - iss_q : iss_q;
          rd_addr   = slot_of(front_q, walk_pos);
          rd_pos_d  = walk_pos[IDX_W-1:0];
          rd_vld_d  = 1'b1;
          rd_last_d = (iss_q == occ_q - 1'b1);
          iss_d     = iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (mode_q == MODE_REPORT) begin
            res_total_d = res_total_q + TOTAL_W'(rd_val);
            if (rd_pos_q == '0) begin
              res_min_d = rd_val;
              res_max_d = rd_val;
            end else begin
              if (rd_val < res_min_q) res_min_d = rd_val;
              if (rd_val > res_max_q) res_max_d = rd_val;
            end
          end else if (!hit_q && match) begin
            hit_d     = 1'b1;
            res_idx_d = rd_pos_q;
          end
          if (rd_last_q) begin
            state_d = S_EMIT;
            if (mode_q != MODE_REPORT && !hit_d) res_status_d = ST_NOT_FOUND;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    value_q      <= value_d;
    rd_pos_q     <= rd_pos_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_count_q  <= res_count_d;
    res_min_q    <= res_min_d;
    res_max_q    <= res_max_d;
    res_total_q  <= res_total_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_count_q  <= res_count_q;
      out_min_q    <= res_min_q;
      out_max_q    <= res_max_q;
      out_total_q  <= res_total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= req_i.value;
    rd_data_q <= mem_q[rd_addr];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_index = out_idx_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.min_value   = out_min_q;
  assign rsp_o.max_value   = out_max_q;
  assign rsp_o.total       = out_total_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(front_q) < SUM_W'(DEPTH))
    else $error("front pointer beyond depth");

  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_WALK)
    else $error("read data outside walk");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q != S_IDLE)
    else $error("accepted transaction left no work");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && (!out_valid_q || rsp_o.ready) |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");

endmodule
